[hdl/icfs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package icfs_pkg;

  localparam int unsigned LINE_BYTES = 16;
  localparam int unsigned SETS = 32;
  localparam int unsigned WAYS = 4;

  localparam int unsigned WORDS = LINE_BYTES / 4;
  localparam int unsigned OFF_W = $clog2(LINE_BYTES);
  localparam int unsigned SET_W = $clog2(SETS);
  localparam int unsigned WAY_W = $clog2(WAYS);
  localparam int unsigned WORD_W = $clog2(WORDS);
  localparam int unsigned TAG_W = 32 - OFF_W;
  localparam int unsigned LINES = SETS * WAYS;
  localparam int unsigned LIDX_W = SET_W + WAY_W;
  localparam int unsigned DIDX_W = LIDX_W + WORD_W;

  typedef enum logic [1:0] {
    CMD_FETCH    = 2'd0,
    CMD_INV_LINE = 2'd1,
    CMD_INV_ALL  = 2'd2,
    CMD_FILL     = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_ACK    = 3'd0,
    KIND_DATA   = 3'd1,
    KIND_MISS   = 3'd2,
    KIND_FAULT  = 3'd3,
    KIND_DENIED = 3'd4,
    KIND_BUSY   = 3'd5
  } kind_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] address;
    logic [2:0]  size;
    logic        privileged;
    logic [31:0] fill_word;
    logic        fill_ok;
    logic [7:0]  fill_fault;
  } in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] read_data;
    logic [31:0] line_address;
    logic [7:0]  fault_status;
  } out_t;

endpackage
`default_nettype wire

[hdl/icfs_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module icfs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

[hdl/instruction_cache_fifo_sets_unit.sv]
// busy, invalidate-all and fill-word acks come from decode; inv line probes every way
// a fetch miss probes every way; a hit and the last fill word end in a line-word gather
// one item at a time: the way search shares one tag ram read port and one tag compare
// the next item is taken once the block is idle and the result register is free
// reset clears all line valid bits, fifo pointers and the pending fill at once, no sweep
`timescale 1ns / 1ps
`default_nettype none
module instruction_cache_fifo_sets_unit
  import icfs_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_DECODE, ST_SEARCH, ST_COMPARE, ST_GATHER0, ST_GATHER1, ST_GATHER2
  } state_e;

  state_e state_q;
  in_t item_q;
  logic [2:0] nbytes_q;
  logic [WAY_W-1:0] way_q;
  logic [WAY_W-1:0] cnt_q;
  logic [LINES-1:0] valid_q;
  logic [WAY_W-1:0] ptr_q [SETS];
  logic fill_pending_q;
  logic [SET_W-1:0] fc_set_q;
  logic [WAY_W-1:0] fc_way_q;
  logic [OFF_W-1:0] fc_off_q;
  logic [2:0] fc_size_q;
  logic [WORD_W-1:0] fc_count_q;
  logic [SET_W-1:0] g_set_q;
  logic [WAY_W-1:0] g_way_q;
  logic [OFF_W-1:0] g_off_q;
  logic [2:0] g_n_q;
  kind_e g_kind_q;
  logic [31:0] w0_q;
  logic out_valid_q;
  out_t out_q;

  logic [SET_W-1:0] set;
  logic [LIDX_W-1:0] lidx;
  logic tag_we;
  logic [TAG_W:0] tag_rdata;
  logic data_we;
  logic [DIDX_W-1:0] data_raddr;
  logic [WORD_W-1:0] gword;
  logic [31:0] data_rdata;
  logic match;
  logic [63:0] pair;
  logic [31:0] shifted;
  logic [31:0] mask;
  logic [2:0] nbytes;

  assign set = item_q.address[OFF_W+SET_W-1:OFF_W];
  assign lidx = {set, way_q};
  assign match = valid_q[lidx] && (tag_rdata[TAG_W:1] == item_q.address[31:OFF_W]);

  assign tag_we = (state_q == ST_COMPARE) && (item_q.command == CMD_FETCH) && !match
                  && (cnt_q == WAY_W'(WAYS - 1));
  assign data_we = (state_q == ST_DECODE) && (item_q.command == CMD_FILL)
                   && fill_pending_q && item_q.fill_ok;

  always_comb begin
    gword = g_off_q[OFF_W-1:2];
    if (state_q == ST_GATHER1) begin
      gword = g_off_q[OFF_W-1:2] + WORD_W'(1);
    end
    data_raddr = {g_set_q, g_way_q, gword};
  end

  always_comb begin
    unique case (item_q.size)
      3'd0:       nbytes = 3'd1;
      3'd1:       nbytes = 3'd1;
      3'd2:       nbytes = 3'd2;
      3'd3:       nbytes = 3'd3;
      default:    nbytes = 3'd4;
    endcase
  end

  // bytes past the end of the line wrap into the same line
  assign pair = {data_rdata, w0_q} >> {g_off_q[1:0], 3'b000};
  assign shifted = pair[31:0];
  always_comb begin
    unique case (g_n_q)
      3'd1:    mask = 32'h0000_00ff;
      3'd2:    mask = 32'h0000_ffff;
      3'd3:    mask = 32'h00ff_ffff;
      default: mask = 32'hffff_ffff;
    endcase
  end

  icfs_ram #(.Width(TAG_W + 1), .Depth(LINES)) u_tag_ram (
    .clk_i  (clk_i),
    .we_i   (tag_we),
    .waddr_i(lidx),
    .wdata_i({item_q.address[31:OFF_W], item_q.privileged}),
    .raddr_i(lidx),
    .rdata_o(tag_rdata)
  );

  icfs_ram #(.Width(32), .Depth(LINES * WORDS)) u_data_ram (
    .clk_i  (clk_i),
    .we_i   (data_we),
    .waddr_i({fc_set_q, fc_way_q, fc_count_q}),
    .wdata_i(item_q.fill_word),
    .raddr_i(data_raddr),
    .rdata_o(data_rdata)
  );

  assign in_stall_o = !((state_q == ST_IDLE) && (!out_valid_q || !out_stall_i));
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= '0;
      for (int s = 0; s < SETS; s++) begin
        ptr_q[s] <= '0;
      end
      fill_pending_q <= 1'b0;
      fc_set_q <= '0;
      fc_way_q <= '0;
      fc_off_q <= '0;
      fc_size_q <= '0;
      fc_count_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i && !in_stall_o) begin
            item_q <= in_data_i;
            state_q <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          nbytes_q <= nbytes;
          way_q <= ptr_q[set] - WAY_W'(1);
          cnt_q <= '0;
          out_q <= '0;
          state_q <= ST_IDLE;
          if (item_q.command == CMD_FILL) begin
            out_valid_q <= 1'b1;
            out_q.kind <= KIND_ACK;
            if (fill_pending_q && !item_q.fill_ok) begin
              fill_pending_q <= 1'b0;
              out_q.kind <= KIND_FAULT;
              out_q.fault_status <= item_q.fill_fault;
            end else if (fill_pending_q) begin
              fc_count_q <= fc_count_q + WORD_W'(1);
              if (fc_count_q == WORD_W'(WORDS - 1)) begin
                fill_pending_q <= 1'b0;
                valid_q[{fc_set_q, fc_way_q}] <= 1'b1;
                g_set_q <= fc_set_q;
                g_way_q <= fc_way_q;
                g_off_q <= fc_off_q;
                g_n_q <= fc_size_q;
                g_kind_q <= KIND_DATA;
                out_valid_q <= 1'b0;
                state_q <= ST_GATHER0;
              end
            end
          end else if (fill_pending_q) begin
            out_valid_q <= 1'b1;
            out_q.kind <= KIND_BUSY;
          end else if (item_q.command == CMD_INV_ALL) begin
            valid_q <= '0;
            for (int s = 0; s < SETS; s++) begin
              ptr_q[s] <= '0;
            end
            out_valid_q <= 1'b1;
            out_q.kind <= KIND_ACK;
          end else begin
            state_q <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          state_q <= ST_COMPARE;
        end
        ST_COMPARE: begin
          // probe ways from the newest fill backwards
          way_q <= way_q - WAY_W'(1);
          cnt_q <= cnt_q + WAY_W'(1);
          state_q <= ST_SEARCH;
          if (item_q.command == CMD_INV_LINE) begin
            if (match) begin
              valid_q[lidx] <= 1'b0;
            end
            if (cnt_q == WAY_W'(WAYS - 1)) begin
              out_valid_q <= 1'b1;
              out_q.kind <= KIND_ACK;
              state_q <= ST_IDLE;
            end
          end else if (match) begin
            g_set_q <= set;
            g_way_q <= way_q;
            g_off_q <= item_q.address[OFF_W-1:0];
            g_n_q <= nbytes_q;
            g_kind_q <= (item_q.privileged || !tag_rdata[0]) ? KIND_DATA : KIND_DENIED;
            state_q <= ST_GATHER0;
          end else if (cnt_q == WAY_W'(WAYS - 1)) begin
            // way_q has wrapped back to the fifo victim
            valid_q[lidx] <= 1'b0;
            ptr_q[set] <= way_q + WAY_W'(1);
            fill_pending_q <= 1'b1;
            fc_set_q <= set;
            fc_way_q <= way_q;
            fc_off_q <= item_q.address[OFF_W-1:0];
            fc_size_q <= nbytes_q;
            fc_count_q <= '0;
            out_valid_q <= 1'b1;
            out_q.kind <= KIND_MISS;
            out_q.line_address <= {item_q.address[31:OFF_W], OFF_W'(0)};
            state_q <= ST_IDLE;
          end
        end
        ST_GATHER0: begin
          state_q <= ST_GATHER1;
        end
        ST_GATHER1: begin
          w0_q <= data_rdata;
          state_q <= ST_GATHER2;
        end
        ST_GATHER2: begin
          out_valid_q <= 1'b1;
          out_q.kind <= g_kind_q;
          out_q.read_data <= shifted & mask;
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_GATHER2 |-> $past(state_q) == ST_GATHER1)
    else $error("gather out of sequence");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tag_we |=> fill_pending_q)
    else $error("victim tagged without a pending fill");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> state_q == ST_IDLE)
    else $error("work in flight while a result is held");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    data_we |-> state_q == ST_DECODE && fill_pending_q)
    else $error("line word written outside a fill");

endmodule
`default_nettype wire

[dv/icfs_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module icfs_checker
  import icfs_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic in_stall_i,
  input  wire in_t  in_data_i,
  input  wire logic out_valid_i,
  input  wire logic out_stall_i,
  input  wire out_t out_data_i,
  output int        fail_count_o,
  output int        pending_o,
  output int        hit_count_o,
  output int        miss_count_o,
  output int        fault_count_o
);

  logic [31:0] tags_q [SETS][WAYS];
  logic [31:0] words_q [SETS][WAYS][WORDS];
  int unsigned fifo_q [SETS];
  bit          filling;
  int unsigned f_set, f_way, f_off, f_size, f_count;
  out_t        expected_q[$];

  function automatic logic [31:0] gather_bytes(int unsigned s, int unsigned w,
                                               int unsigned o, int unsigned n);
    logic [31:0] r;
    int unsigned b;
    r = '0;
    for (int k = 0; k < n; k++) begin
      b = (o + k) % LINE_BYTES;
      r[k*8 +: 8] = words_q[s][w][b / 4][(b % 4) * 8 +: 8];
    end
    return r;
  endfunction

  function automatic out_t cache_step(in_t it);
    out_t        r;
    int unsigned off, s, j, n, v;
    logic [31:0] base, t;
    r = '0;
    off = it.address % LINE_BYTES;
    base = it.address - off;
    s = (it.address / LINE_BYTES) % SETS;
    if (cmd_e'(it.command) == CMD_FILL) begin
      if (!filling) begin
        r.kind = KIND_ACK;
      end else if (!it.fill_ok) begin
        filling = 0;
        r.kind = KIND_FAULT;
        r.fault_status = it.fill_fault;
      end else begin
        words_q[f_set][f_way][f_count] = it.fill_word;
        f_count++;
        if (f_count < WORDS) begin
          r.kind = KIND_ACK;
        end else begin
          filling = 0;
          tags_q[f_set][f_way][0] = 1'b1;
          r.kind = KIND_DATA;
          r.read_data = gather_bytes(f_set, f_way, f_off, f_size);
        end
      end
      return r;
    end
    if (filling) begin
      r.kind = KIND_BUSY;
      return r;
    end
    if (cmd_e'(it.command) == CMD_INV_ALL) begin
      foreach (tags_q[a, b]) tags_q[a][b] = '0;
      foreach (fifo_q[a]) fifo_q[a] = 0;
      r.kind = KIND_ACK;
      return r;
    end
    if (cmd_e'(it.command) == CMD_INV_LINE) begin
      for (int w = 0; w < WAYS; w++)
        if (tags_q[s][w][0] && {tags_q[s][w][31:OFF_W], {OFF_W{1'b0}}} == base)
          tags_q[s][w] = '0;
      r.kind = KIND_ACK;
      return r;
    end
    n = it.size == 0 ? 1 : (it.size > 4 ? 4 : it.size);
    j = fifo_q[s];
    for (int i = 0; i < WAYS; i++) begin
      j = (j == 0) ? WAYS - 1 : j - 1;
      t = tags_q[s][j];
      if (t[0] && {t[31:OFF_W], {OFF_W{1'b0}}} == base) begin
        r.kind = (it.privileged || !t[1]) ? KIND_DATA : KIND_DENIED;
        r.read_data = gather_bytes(s, j, off, n);
        hit_count_o++;
        return r;
      end
    end
    v = fifo_q[s];
    fifo_q[s] = (v + 1) % WAYS;
    tags_q[s][v] = base | (it.privileged ? 32'd2 : 32'd0);
    filling = 1;
    f_set = s; f_way = v; f_off = off; f_size = n; f_count = 0;
    r.kind = KIND_MISS;
    r.line_address = base;
    miss_count_o++;
    return r;
  endfunction

  initial begin
    foreach (tags_q[a, b]) tags_q[a][b] = '0;
    foreach (fifo_q[a]) fifo_q[a] = 0;
    filling = 0;
    fail_count_o = 0;
    hit_count_o = 0;
    miss_count_o = 0;
    fault_count_o = 0;
  end

  always @(posedge clk_i) begin
    out_t e;
    if (rst_ni && in_valid_i && !in_stall_i) begin
      e = cache_step(in_data_i);
      if (e.kind == KIND_FAULT) fault_count_o++;
      expected_q.push_back(e);
    end
    if (rst_ni && out_valid_i && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected: kind %0d", out_data_i.kind);
        fail_count_o++;
      end else begin
        e = expected_q.pop_front();
        if (out_data_i.kind !== e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, out_data_i.kind);
          fail_count_o++;
        end
        if (out_data_i.read_data !== e.read_data) begin
          $error("read_data: expected %h, got %h", e.read_data, out_data_i.read_data);
          fail_count_o++;
        end
        if (out_data_i.line_address !== e.line_address) begin
          $error("line_address: expected %h, got %h", e.line_address,
                 out_data_i.line_address);
          fail_count_o++;
        end
        if (out_data_i.fault_status !== e.fault_status) begin
          $error("fault_status: expected %h, got %h", e.fault_status,
                 out_data_i.fault_status);
          fail_count_o++;
        end
      end
    end
    pending_o <= expected_q.size();
  end

endmodule
`default_nettype wire

[dv/instruction_cache_fifo_sets_unit_tb.sv]
`timescale 1ns / 1ps
`default_nettype none
module instruction_cache_fifo_sets_unit_tb;
  import icfs_pkg::*;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic in_stall_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 0;
  out_t out_data_o;
  int   fail_count, pending, hits, misses, faults;
  int   sent = 0;
  int   burst_left = 0;

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  instruction_cache_fifo_sets_unit DUT (.*);

  icfs_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .fail_count_o(fail_count), .pending_o(pending), .hit_count_o(hits),
    .miss_count_o(misses), .fault_count_o(faults)
  );

  // receiver stall pattern, with calm stretches
  always @(negedge clk_i) begin
    int r;
    r = $urandom_range(0, 99);
    if ((sent / 200) % 3 == 1) out_stall_i <= 1'b0;
    else out_stall_i <= (r < 30);
  end

  // addresses drawn from a small pool so lines get hit, evicted and refilled
  function automatic logic [31:0] pick_address();
    logic [31:0] a;
    a = $urandom();
    case ($urandom_range(0, 3))
      0: a = {$urandom_range(0, 5) * 32'h1000 + $urandom_range(0, 3) * 32'h200}
             + a[8:0];
      1: a = {20'd0, a[11:0]};
      default: a = {30'($urandom_range(0, 7)), 2'b00} * 32'h10 + a[3:0];
    endcase
    return a;
  endfunction

  // valid is driven with blocking writes so a beat can follow the previous one
  // at the same falling edge
  task automatic send_beat(in_t it);
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 4)) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_data_i = it;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    sent++;
  endtask

  function automatic in_t make_beat(cmd_e c, logic [31:0] a, logic [2:0] sz, logic p);
    in_t it;
    it = '0;
    it.command = c; it.address = a; it.size = sz; it.privileged = p;
    it.fill_word = $urandom(); it.fill_ok = 1'b1; it.fill_fault = 8'($urandom());
    return it;
  endfunction

  task automatic fill_line(bit fail_ok);
    in_t it;
    for (int w = 0; w < WORDS; w++) begin
      it = make_beat(CMD_FILL, $urandom(), 3'($urandom()), 1'($urandom()));
      if (fail_ok && $urandom_range(0, 15) == 0) it.fill_ok = 1'b0;
      send_beat(it);
      if (!it.fill_ok) break;
    end
  endtask

  task automatic fetch_with_fill(logic [31:0] a, logic [2:0] sz, logic p, bit fail_ok);
    int m;
    m = misses;
    send_beat(make_beat(CMD_FETCH, a, sz, p));
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    @(negedge clk_i);
    if (misses != m) fill_line(fail_ok);
  endtask

  initial begin
    in_t it;
    int  r;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // directed
    send_beat(make_beat(CMD_FILL, 32'h0, 3'd1, 1'b0));
    fetch_with_fill(32'hFFFF_FFFC, 3'd4, 1'b1, 1'b0);
    fetch_with_fill(32'hFFFF_FFFE, 3'd4, 1'b0, 1'b0);
    fetch_with_fill(32'h0000_0000, 3'd0, 1'b0, 1'b0);
    fetch_with_fill(32'h0000_0003, 3'd7, 1'b0, 1'b0);
    fetch_with_fill(32'h0000_0001, 3'd2, 1'b1, 1'b0);
    fetch_with_fill(32'h0000_000F, 3'd3, 1'b0, 1'b0);
    send_beat(make_beat(CMD_FETCH, 32'h0000_0200, 3'd4, 1'b0));
    send_beat(make_beat(CMD_FETCH, 32'h0, 3'd1, 1'b0));
    send_beat(make_beat(CMD_INV_LINE, 32'h0, 3'd1, 1'b0));
    send_beat(make_beat(CMD_INV_ALL, 32'h0, 3'd1, 1'b0));
    it = make_beat(CMD_FILL, 32'h0, 3'd1, 1'b0);
    it.fill_ok = 1'b0; it.fill_fault = 8'hFF;
    send_beat(it);
    send_beat(make_beat(CMD_INV_LINE, 32'hFFFF_FFF0, 3'd1, 1'b0));
    fetch_with_fill(32'hFFFF_FFF0, 3'd4, 1'b1, 1'b0);
    send_beat(make_beat(CMD_INV_ALL, 32'h0, 3'd1, 1'b0));
    // random
    while (sent < 1250) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        fetch_with_fill(pick_address(), 3'($urandom()), 1'($urandom()), 1'b1);
      end else if (r < 75) begin
        send_beat(make_beat(CMD_FETCH, pick_address(), 3'($urandom()),
                            1'($urandom())));
      end else if (r < 85) begin
        send_beat(make_beat(CMD_INV_LINE, pick_address(), 3'($urandom()),
                            1'($urandom())));
      end else if (r < 88) begin
        send_beat(make_beat(CMD_INV_ALL, $urandom(), 3'($urandom()), 1'($urandom())));
      end else begin
        it = make_beat(CMD_FILL, $urandom(), 3'($urandom()), 1'($urandom()));
        it.fill_ok = 1'($urandom());
        send_beat(it);
      end
    end
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("sent %0d beats: %0d hits, %0d misses, %0d fill faults", sent, hits,
             misses, faults);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
`default_nettype wire
